/* sv/ethernet_ipv4_header_parser_stats_unit_macros.svh */
// Assertion macros used by the statistics logic.
`ifndef ETHERNET_IPV4_HEADER_PARSER_STATS_UNIT_MACROS_SVH
`define ETHERNET_IPV4_HEADER_PARSER_STATS_UNIT_MACROS_SVH

// Same-cycle implication.
`define EIHPS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EIHPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/eihps_pkg.sv */
package eihps_pkg;

  localparam int ETH_HDR_LEN   = 14;
  localparam int IP_MIN_LEN    = 34;
  localparam int ETH_TYPE_POS  = 12;
  localparam int IHL_POS       = 14;
  localparam int PROTO_POS     = 23;
  localparam int SRC_ADDR_POS  = 26;
  localparam int DST_ADDR_POS  = 30;
  localparam int TCP_HDR_MIN   = 20;
  localparam int UDP_HDR_LEN   = 8;
  localparam int L4_OFFSET_W   = 7;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam logic [7:0]  TCP_PROTOCOL   = 8'd6;
  localparam logic [7:0]  UDP_PROTOCOL   = 8'd17;
  localparam logic [7:0]  ICMP_PROTOCOL  = 8'd1;

  typedef struct packed {
    logic                   clear;
    logic [15:0]            ethertype;
    logic [7:0]             protocol;
    logic [31:0]            src_addr;
    logic [31:0]            dst_addr;
    logic [15:0]            l4_sport;
    logic [15:0]            l4_dport;
    logic [L4_OFFSET_W-1:0] l4_offset;
  } eihps_frame_t;

endpackage

/* sv/eihps_in_if.sv */
interface eihps_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output cmd, output data_byte, output last, input ready);
  modport sink (input valid, input cmd, input data_byte, input last, output ready);
endinterface

/* sv/eihps_out_if.sv */
interface eihps_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [31:0] packet_total;
  logic [47:0] byte_total;
  logic [31:0] tcp_total;
  logic [31:0] udp_total;
  logic [31:0] icmp_total;
  logic [31:0] other_total;

  modport source (
    output valid, output accepted, output protocol, output source_address,
    output destination_address, output source_port, output destination_port,
    output packet_total, output byte_total, output tcp_total, output udp_total,
    output icmp_total, output other_total, input ready
  );
  modport sink (
    input valid, input accepted, input protocol, input source_address,
    input destination_address, input source_port, input destination_port,
    input packet_total, input byte_total, input tcp_total, input udp_total,
    input icmp_total, input other_total, output ready
  );
endinterface

/* sv/eihps_capture.sv */
module eihps_capture #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  eihps_in_if.sink                frame_i,
  output logic                    s_valid_o,
  input  logic                    s_ready_i,
  output eihps_pkg::eihps_frame_t s_frame_o,
  output logic [LENGTH_BITS-1:0]  s_len_o
);

  localparam int LW = eihps_pkg::L4_OFFSET_W;

  logic [LENGTH_BITS-1:0] pos_q, pos_d, len_inc, rel;
  logic                   xfer, byte_xfer;
  logic [15:0]            eth_q, eth_d;
  logic [3:0]             ihl_q, ihl_d, ihl_cur;
  logic [7:0]             ihl_byte;
  logic [7:0]             proto_q, proto_d;
  logic [31:0]            sa_q, sa_d, da_q, da_d;
  logic [15:0]            sp_q, sp_d, dp_q, dp_d;
  logic [LW-1:0]          l4;
  logic                   sv_q;
  eihps_pkg::eihps_frame_t sf_q;
  logic [LENGTH_BITS-1:0] sl_q;

  assign frame_i.ready = !sv_q || s_ready_i;
  assign xfer          = frame_i.valid && frame_i.ready;
  assign byte_xfer     = xfer && !frame_i.cmd;

  assign len_inc  = (pos_q == '1) ? pos_q : pos_q + LENGTH_BITS'(1);
  assign ihl_byte = frame_i.data_byte & eihps_pkg::IHL_MASK;
  assign ihl_cur  = (pos_q == LENGTH_BITS'(eihps_pkg::IHL_POS)) ? ihl_byte[3:0] : ihl_q;
  assign l4       = LW'(eihps_pkg::ETH_HDR_LEN) + {1'b0, ihl_cur, 2'b00};
  assign rel      = pos_q - LENGTH_BITS'(l4);

  always_comb begin
    pos_d   = pos_q;
    eth_d   = eth_q;
    ihl_d   = ihl_q;
    proto_d = proto_q;
    sa_d    = sa_q;
    da_d    = da_q;
    sp_d    = sp_q;
    dp_d    = dp_q;
    if (byte_xfer) begin
      pos_d = frame_i.last ? '0 : len_inc;
      if (pos_q >= LENGTH_BITS'(eihps_pkg::ETH_TYPE_POS) &&
          pos_q < LENGTH_BITS'(eihps_pkg::ETH_TYPE_POS + 2)) begin
        eth_d = {eth_q[7:0], frame_i.data_byte};
      end
      if (pos_q == LENGTH_BITS'(eihps_pkg::IHL_POS)) begin
        ihl_d = ihl_byte[3:0];
      end
      if (pos_q == LENGTH_BITS'(eihps_pkg::PROTO_POS)) begin
        proto_d = frame_i.data_byte;
      end
      if (pos_q >= LENGTH_BITS'(eihps_pkg::SRC_ADDR_POS) &&
          pos_q < LENGTH_BITS'(eihps_pkg::SRC_ADDR_POS + 4)) begin
        sa_d = {sa_q[23:0], frame_i.data_byte};
      end
      if (pos_q >= LENGTH_BITS'(eihps_pkg::DST_ADDR_POS) &&
          pos_q < LENGTH_BITS'(eihps_pkg::DST_ADDR_POS + 4)) begin
        da_d = {da_q[23:0], frame_i.data_byte};
      end
      if (pos_q >= LENGTH_BITS'(l4) && rel[LENGTH_BITS-1:2] == '0) begin
        if (rel[1]) begin
          dp_d = {dp_q[7:0], frame_i.data_byte};
        end else begin
          sp_d = {sp_q[7:0], frame_i.data_byte};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sv_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (xfer && (frame_i.cmd || frame_i.last)) begin
        sv_q <= 1'b1;
      end else if (s_ready_i) begin
        sv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eth_q   <= eth_d;
    ihl_q   <= ihl_d;
    proto_q <= proto_d;
    sa_q    <= sa_d;
    da_q    <= da_d;
    sp_q    <= sp_d;
    dp_q    <= dp_d;
    if (xfer && (frame_i.cmd || frame_i.last)) begin
      sf_q.clear     <= frame_i.cmd;
      sf_q.ethertype <= eth_d;
      sf_q.protocol  <= proto_d;
      sf_q.src_addr  <= sa_d;
      sf_q.dst_addr  <= da_d;
      sf_q.l4_sport  <= sp_d;
      sf_q.l4_dport  <= dp_d;
      sf_q.l4_offset <= LW'(eihps_pkg::ETH_HDR_LEN) + {1'b0, ihl_d, 2'b00};
      sl_q           <= len_inc;
    end
  end

  assign s_valid_o = sv_q;
  assign s_frame_o = sf_q;
  assign s_len_o   = sl_q;

endmodule

/* sv/eihps_stats.sv */
`include "ethernet_ipv4_header_parser_stats_unit_macros.svh"

module eihps_stats #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  eihps_pkg::eihps_frame_t s_frame_i,
  input  logic [LENGTH_BITS-1:0]  s_len_i,
  eihps_out_if.source             result_o
);

  localparam int LW = eihps_pkg::L4_OFFSET_W;

  logic        take, acc, ipv4, is_tcp, is_udp, is_icmp, ports_ok;
  logic [31:0] pkt_q, pkt_d, tcp_q, tcp_d, udp_q, udp_d, icmp_q, icmp_d, oth_q, oth_d;
  logic [47:0] bytes_q, bytes_d;
  logic        ov_q;
  logic        acc_q;
  logic [7:0]  proto_q;
  logic [31:0] sa_q, da_q;
  logic [15:0] sp_q, dp_q;
  logic [31:0] pkt_o_q, tcp_o_q, udp_o_q, icmp_o_q, oth_o_q;
  logic [47:0] bytes_o_q;

  assign s_ready_o = !ov_q || result_o.ready;
  assign take      = s_valid_i && s_ready_o;

  assign acc     = s_len_i >= LENGTH_BITS'(eihps_pkg::ETH_HDR_LEN);
  assign ipv4    = acc && s_frame_i.ethertype == eihps_pkg::ETHERTYPE_IPV4 &&
                   s_len_i >= LENGTH_BITS'(eihps_pkg::IP_MIN_LEN);
  assign is_tcp  = ipv4 && s_frame_i.protocol == eihps_pkg::TCP_PROTOCOL;
  assign is_udp  = ipv4 && s_frame_i.protocol == eihps_pkg::UDP_PROTOCOL;
  assign is_icmp = ipv4 && s_frame_i.protocol == eihps_pkg::ICMP_PROTOCOL;

  always_comb begin
    ports_ok = 1'b0;
    if (is_tcp) begin
      ports_ok = s_len_i >= LENGTH_BITS'(s_frame_i.l4_offset + LW'(eihps_pkg::TCP_HDR_MIN));
    end else if (is_udp) begin
      ports_ok = s_len_i >= LENGTH_BITS'(s_frame_i.l4_offset + LW'(eihps_pkg::UDP_HDR_LEN));
    end
  end

  always_comb begin
    pkt_d   = pkt_q;
    bytes_d = bytes_q;
    tcp_d   = tcp_q;
    udp_d   = udp_q;
    icmp_d  = icmp_q;
    oth_d   = oth_q;
    if (s_frame_i.clear) begin
      pkt_d   = '0;
      bytes_d = '0;
      tcp_d   = '0;
      udp_d   = '0;
      icmp_d  = '0;
      oth_d   = '0;
    end else if (acc) begin
      pkt_d   = pkt_q + 32'd1;
      bytes_d = bytes_q + 48'(s_len_i);
      if (is_tcp) begin
        tcp_d = tcp_q + 32'd1;
      end else if (is_udp) begin
        udp_d = udp_q + 32'd1;
      end else if (is_icmp) begin
        icmp_d = icmp_q + 32'd1;
      end else begin
        oth_d = oth_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q   <= '0;
      bytes_q <= '0;
      tcp_q   <= '0;
      udp_q   <= '0;
      icmp_q  <= '0;
      oth_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (take) begin
        pkt_q   <= pkt_d;
        bytes_q <= bytes_d;
        tcp_q   <= tcp_d;
        udp_q   <= udp_d;
        icmp_q  <= icmp_d;
        oth_q   <= oth_d;
      end
      if (take && !s_frame_i.clear) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !s_frame_i.clear) begin
      acc_q     <= acc;
      proto_q   <= ipv4 ? s_frame_i.protocol : 8'd0;
      sa_q      <= ipv4 ? s_frame_i.src_addr : 32'd0;
      da_q      <= ipv4 ? s_frame_i.dst_addr : 32'd0;
      sp_q      <= ports_ok ? s_frame_i.l4_sport : 16'd0;
      dp_q      <= ports_ok ? s_frame_i.l4_dport : 16'd0;
      pkt_o_q   <= pkt_d;
      bytes_o_q <= bytes_d;
      tcp_o_q   <= tcp_d;
      udp_o_q   <= udp_d;
      icmp_o_q  <= icmp_d;
      oth_o_q   <= oth_d;
    end
  end

  assign result_o.valid               = ov_q;
  assign result_o.accepted            = acc_q;
  assign result_o.protocol            = proto_q;
  assign result_o.source_address      = sa_q;
  assign result_o.destination_address = da_q;
  assign result_o.source_port         = sp_q;
  assign result_o.destination_port    = dp_q;
  assign result_o.packet_total        = pkt_o_q;
  assign result_o.byte_total          = bytes_o_q;
  assign result_o.tcp_total           = tcp_o_q;
  assign result_o.udp_total           = udp_o_q;
  assign result_o.icmp_total          = icmp_o_q;
  assign result_o.other_total         = oth_o_q;

  `EIHPS_ASSERT_NEXT(a_clear_zeroes, clk_i, rst_ni, take && s_frame_i.clear,
    pkt_q == 32'd0 && bytes_q == 48'd0 && oth_q == 32'd0, "counters not cleared")
  `EIHPS_ASSERT_NEXT(a_pkt_count, clk_i, rst_ni, take && !s_frame_i.clear && acc,
    pkt_q == $past(pkt_q) + 32'd1, "packet counter did not advance")
  `EIHPS_ASSERT_IMPL(a_reject_empty, clk_i, rst_ni, ov_q && !acc_q,
    proto_q == 8'd0 && sa_q == 32'd0 && sp_q == 16'd0, "rejected frame has header fields")
  `EIHPS_ASSERT_IMPL(a_ports_l4, clk_i, rst_ni, ov_q && (sp_q != 16'd0 || dp_q != 16'd0),
    proto_q == eihps_pkg::TCP_PROTOCOL || proto_q == eihps_pkg::UDP_PROTOCOL,
    "ports reported for a frame that is neither TCP nor UDP")

endmodule

/* sv/ethernet_ipv4_header_parser_stats_unit.sv */
// Ethernet/IPv4 header parser with traffic statistics.
// The frame_i channel carries one item per transfer: a frame byte in wire order
// with a last flag, or a clear command that zeroes all statistics counters.
// Header fields are picked off the byte stream as they pass, so one byte is
// taken in every cycle while frame_i.ready is high and frames may follow each
// other with no gap. The result_o channel carries one result for each frame,
// registered in the summary and then the result register: the accept flag,
// the IPv4 protocol and addresses, the TCP or UDP ports and the counter values
// after that frame. A clear command produces no result and leaves a frame in
// progress untouched. Frame length saturates at LENGTH_BITS bits.
// A frame summary register and the result register sit between the two
// channels, so new bytes are taken while a result waits to be taken. When the
// receiver stalls, the result holds, the summary register fills and then
// frame_i.ready drops until result_o transfers.
// Reset clears the length count, all counters and both valid flags; the block
// takes bytes as soon as reset is released.
module ethernet_ipv4_header_parser_stats_unit #(
  parameter int LENGTH_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  eihps_in_if.sink    frame_i,
  eihps_out_if.source result_o
);

  logic                    s_valid, s_ready;
  eihps_pkg::eihps_frame_t s_frame;
  logic [LENGTH_BITS-1:0]  s_len;

  eihps_capture #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame_i),
    .s_valid_o (s_valid),
    .s_ready_i (s_ready),
    .s_frame_o (s_frame),
    .s_len_o   (s_len)
  );

  eihps_stats #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_valid),
    .s_ready_o (s_ready),
    .s_frame_i (s_frame),
    .s_len_i   (s_len),
    .result_o  (result_o)
  );

endmodule
